// File: rtl/skt_pkg.sv
// Shared types, widths and codes for the sorted key table.
// No dependencies; imported by every module of the block but skt_ram.
package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 16;
    localparam int MASK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = KEY_W + MASK_W;

    localparam int S_TDATA_W = ((MODE_W + KEY_W + MASK_W + 7) / 8) * 8;
    localparam int M_FIELD_W = STATUS_W + MASK_W + CNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // table read address select
    localparam logic [1:0] RD_MID  = 2'd0;
    localparam logic [1:0] RD_LO   = 2'd1;
    localparam logic [1:0] RD_DOWN = 2'd2;
    localparam logic [1:0] RD_UP   = 2'd3;

    typedef struct packed {
        logic                in_load;
        logic                srch_init;
        logic                srch_upd;
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                chk_latch;
        logic                ptr_from_lo;
        logic                ptr_from_cnt;
        logic                wr_shift;
        logic                ptr_dec;
        logic                ptr_inc;
        logic                wr_new;
        logic                cnt_inc;
        logic                cnt_dec;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              is_full;
        logic              lo_lt_hi;
        logic              found;
        logic              ptr_gt_lo;
        logic              ptr_up_lt_cnt;
        logic              out_free;
    } dp_stat_t;

endpackage

// File: rtl/skt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/skt_dp.sv
// Datapath: operand registers, search bounds, shift pointer, entry count,
// table RAM and result register. Depends on skt_pkg and skt_ram.
module skt_dp
    import skt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    logic [MODE_W-1:0]   mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MASK_W-1:0]   hit_mask_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_FIELD_W-1:0] out_reg;

    logic [CNT_W:0]      mid_sum;
    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    ptr_dn;
    logic [CNT_W:0]      ptr_up;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ENTRY_W-1:0]  rd_data;
    logic [KEY_W-1:0]    rd_key;
    logic [MASK_W-1:0]   rd_mask;
    logic                key_lt;
    logic [MASK_W-1:0]   res_events;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign ptr_dn  = ptr_reg - CNT_W'(1);
    assign ptr_up  = {1'b0, ptr_reg} + (CNT_W+1)'(1);

    assign rd_key  = rd_data[KEY_W-1:0];
    assign rd_mask = rd_data[ENTRY_W-1:KEY_W];
    assign key_lt  = $signed(rd_key) < $signed(key_reg);

    always_comb begin
        unique case (cmd.rd_sel)
            RD_MID:  rd_addr = mid[IDX_W-1:0];
            RD_LO:   rd_addr = lo_reg[IDX_W-1:0];
            RD_DOWN: rd_addr = ptr_dn[IDX_W-1:0];
            RD_UP:   rd_addr = ptr_up[IDX_W-1:0];
            default: rd_addr = lo_reg[IDX_W-1:0];
        endcase
    end

    assign wr_addr = cmd.wr_new ? lo_reg[IDX_W-1:0] : ptr_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_new ? {mask_reg, key_reg} : rd_data;

    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.wr_new | cmd.wr_shift),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.srch_init) begin
            lo_next = '0;
            hi_next = count_reg;
        end else if (cmd.srch_upd) begin
            if (key_lt) begin
                lo_next = mid + CNT_W'(1);
            end else begin
                hi_next = mid;
            end
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_from_lo) begin
            ptr_next = lo_reg;
        end else if (cmd.ptr_from_cnt) begin
            ptr_next = count_reg;
        end else if (cmd.ptr_dec) begin
            ptr_next = ptr_dn;
        end else if (cmd.ptr_inc) begin
            ptr_next = ptr_up[CNT_W-1:0];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign res_events = (cmd.res_status == ST_OK && mode_reg == MODE_QUERY) ?
                        hit_mask_reg : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            mode_reg <= s_tdata[MODE_W-1:0];
            key_reg  <= s_tdata[MODE_W +: KEY_W];
            mask_reg <= s_tdata[MODE_W+KEY_W +: MASK_W];
        end
        if (cmd.chk_latch) begin
            hit_mask_reg <= rd_mask;
        end
        if (cmd.out_load) begin
            out_reg <= {count_reg, res_events, cmd.res_status};
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ptr_reg <= ptr_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELD_W)'(0), out_reg};

    assign stat.mode          = mode_reg;
    assign stat.is_full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.lo_lt_hi      = (lo_reg < hi_reg);
    assign stat.found         = (lo_reg < count_reg) && (rd_key == key_reg);
    assign stat.ptr_gt_lo     = (ptr_reg > lo_reg);
    assign stat.ptr_up_lt_cnt = (ptr_up < {1'b0, count_reg});
    assign stat.out_free      = !m_tvalid_reg || m_tready;

    // count stays within the table
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // never insert into a full table
    a_no_inc_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> (count_reg < CNT_W'(TABLE_DEPTH)))
        else $error("insert into full table");

    // never overwrite a pending result
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // shift writes stay inside the table, at or below the entry count
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_shift |-> (ptr_reg < CNT_W'(TABLE_DEPTH)) && (ptr_reg <= count_reg))
        else $error("shift write out of range");

endmodule

// File: rtl/skt_ctrl.sv
// Controller: sequences search, shift, write and result hand-off.
// Depends on skt_pkg; drives the datapath through dp_cmd_t.
module skt_ctrl
    import skt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_SCMP   = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_ADD_RD = 4'd5;
    localparam logic [3:0] S_ADD_WR = 4'd6;
    localparam logic [3:0] S_DEL_RD = 4'd7;
    localparam logic [3:0] S_DEL_WR = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.res_status = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                status_next = ST_OK;
                if (stat.mode == MODE_ADD && stat.is_full) begin
                    status_next = ST_FULL;
                    state_next  = S_FINISH;
                end else if (stat.mode == MODE_ADD || stat.mode == MODE_DELETE ||
                             stat.mode == MODE_QUERY) begin
                    cmd.srch_init = 1'b1;
                    state_next    = S_SRCH;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SRCH: begin
                cmd.rd_en = 1'b1;
                if (stat.lo_lt_hi) begin
                    cmd.rd_sel = RD_MID;
                    state_next = S_SCMP;
                end else begin
                    cmd.rd_sel = RD_LO;
                    state_next = S_CHK;
                end
            end
            S_SCMP: begin
                cmd.srch_upd = 1'b1;
                state_next   = S_SRCH;
            end
            S_CHK: begin
                cmd.chk_latch = 1'b1;
                if (stat.mode == MODE_ADD) begin
                    if (stat.found) begin
                        cmd.wr_new = 1'b1;
                        state_next = S_FINISH;
                    end else begin
                        cmd.ptr_from_cnt = 1'b1;
                        state_next       = S_ADD_RD;
                    end
                end else if (!stat.found) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end else if (stat.mode == MODE_DELETE) begin
                    cmd.ptr_from_lo = 1'b1;
                    state_next      = S_DEL_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_ADD_RD: begin
                if (stat.ptr_gt_lo) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DOWN;
                    state_next = S_ADD_WR;
                end else begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_ADD_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_dec  = 1'b1;
                state_next   = S_ADD_RD;
            end
            S_DEL_RD: begin
                if (stat.ptr_up_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP;
                    state_next = S_DEL_WR;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_DEL_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_inc  = 1'b1;
                state_next   = S_DEL_RD;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

endmodule

// File: rtl/sorted_key_table_top.sv
// Sorted key table: ascending signed keys with event masks; add, delete, query.
// A query or update runs a binary search of the table; an insert or delete then
// shifts the entries behind the slot one place, and a refused add skips the search.
// One transaction in flight, the next accepted the cycle after the result loads.
// Synchronous active-low reset empties the table at once. Needs skt_pkg, skt_ctrl, skt_dp.
module sorted_key_table_top
    import skt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode[1:0], key[17:2], event_mask[33:18]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], entry_events[17:2],
                                            // entry_count[24:18]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: binary search by reads of the table RAM, then a read/write
    // pair for each entry while entries are shifted up or down.
    skt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: operands, bounds, shift pointer, count, table and result
    // register. The result register frees the controller as soon as a
    // transaction is handed over.
    skt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: test/skt_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the sorted key table: predicts each result from the input
// transactions it sees and compares it with the result channel. Uses skt_pkg.
module skt_result_checker
    import skt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int unsigned          fail_count,
    output int unsigned          pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MASK_W-1:0]   events;
        logic [CNT_W-1:0]    count;
    } table_result_t;

    // shadow of the table contents
    logic signed [KEY_W-1:0] key_tab [TABLE_DEPTH];
    logic [MASK_W-1:0]       mask_tab[TABLE_DEPTH];
    int                      used;

    table_result_t expected_q[$];
    table_result_t got, want;

    function automatic table_result_t apply_op(input logic [MODE_W-1:0] op,
                                               input logic signed [KEY_W-1:0] k,
                                               input logic [MASK_W-1:0] msk);
        table_result_t r;
        int            pos;
        bit            hit;
        r   = '0;
        pos = 0;
        // first slot holding a key not below k
        while (pos < used && key_tab[pos] < k)
            pos++;
        hit = (pos < used) && (key_tab[pos] == k);
        case (op)
            MODE_ADD: begin
                if (used >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (!hit) begin
                        for (int i = used; i > pos; i--) begin
                            key_tab[i]  = key_tab[i-1];
                            mask_tab[i] = mask_tab[i-1];
                        end
                        used++;
                    end
                    key_tab[pos]  = k;
                    mask_tab[pos] = msk;
                end
            end
            MODE_DELETE: begin
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = pos; i < used - 1; i++) begin
                        key_tab[i]  = key_tab[i+1];
                        mask_tab[i] = mask_tab[i+1];
                    end
                    used--;
                end
            end
            MODE_QUERY: begin
                if (!hit)
                    r.status = ST_NOT_FOUND;
                else
                    r.events = mask_tab[pos];
            end
            default: ;  // unused code: no change
        endcase
        r.count = CNT_W'(used);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            used       = 0;
            fail_count = 0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[STATUS_W-1:0];
                got.events = m_tdata[STATUS_W +: MASK_W];
                got.count  = m_tdata[STATUS_W+MASK_W +: CNT_W];
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none outstanding: status %0d events %h count %0d",
                             $time, got.status, got.events, got.count);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status: expected %0d, got %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.events !== want.events) begin
                        $display("%0t: entry_events: expected %h, got %h",
                                 $time, want.events, got.events);
                        fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: entry_count: expected %0d, got %0d",
                                 $time, want.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_op(s_tdata[MODE_W-1:0],
                                              s_tdata[MODE_W +: KEY_W],
                                              s_tdata[MODE_W+KEY_W +: MASK_W]));
        end
        pending = expected_q.size();
    end

endmodule

// File: test/tb_sorted_key_table_top.sv
`timescale 1ns / 1ps
// Testbench top for sorted_key_table_top: drives operation transactions and
// random back-pressure. Uses skt_pkg and skt_result_checker.
module tb_sorted_key_table_top
    import skt_pkg::*;
();

    // the fourth operation code has no meaning and must leave the table alone
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // cycles with no transaction on either channel before giving up
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 40;
    // keys per round; more than TABLE_DEPTH so that the fill reaches full
    localparam int POOL_SIZE   = 70;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // mode[1:0], key[17:2], event_mask[33:18]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // status[1:0], entry_events[17:2], entry_count[24:18]

    int unsigned fail_count;
    int unsigned pending;

    int               s_idle_pct;    // chance per cycle that the sender idles
    int               m_stall_pct;   // chance per cycle that the receiver stalls
    int               quiet_cycles;
    logic [KEY_W-1:0] pool_base;
    int               pool_step;
    int               order[POOL_SIZE];

    sorted_key_table_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    skt_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    // watchdog: a hung handshake ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_sorted_key_table_top: errors");
                $finish;
            end
        end
    end

    // Entered and left at a falling edge. Valid stays high from one
    // transaction to the next unless the sender idles in between.
    task automatic send_op(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
                           input logic [MASK_W-1:0] msk);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-MODE_W-KEY_W-MASK_W){1'b0}}, msk, k, op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // any code, any key, any mask
    task automatic send_noise();
        send_op(MODE_W'($urandom), KEY_W'($urandom), MASK_W'($urandom));
    endtask

    // hold the sender off until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pool_key(input int idx);
        return KEY_W'(pool_base + pool_step * idx);
    endfunction

    task automatic shuffle_pool();
        int j, t;
        for (int i = POOL_SIZE - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
    endtask

    // One round: fill the table past full from a key pool in random order,
    // churn mostly on the same pool, then delete the whole pool again.
    task automatic run_round(input int idle_pct, input int stall_pct);
        int roll;
        s_idle_pct  = idle_pct;
        m_stall_pct = stall_pct;
        // a random base may wrap the pool across the sign boundary
        pool_base   = KEY_W'($urandom);
        pool_step   = $urandom_range(1, 3);
        foreach (order[i])
            order[i] = i;
        shuffle_pool();

        foreach (order[i]) begin
            if ($urandom_range(0, 99) < 10)
                send_noise();
            send_op(MODE_ADD, pool_key(order[i]), MASK_W'($urandom));
        end

        // table full: a held key and a fresh key are both refused
        send_op(MODE_ADD, pool_key(order[0]), MASK_W'($urandom));
        send_op(MODE_ADD, KEY_W'($urandom), MASK_W'($urandom));
        send_op(MODE_QUERY, pool_key(order[0]), '0);
        send_op(MODE_QUERY, pool_key(order[POOL_SIZE-1]), '0);

        repeat (60) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                send_op(MODE_QUERY, pool_key($urandom_range(0, POOL_SIZE - 1)),
                        MASK_W'($urandom));
            else if (roll < 60)
                send_op(MODE_ADD, pool_key($urandom_range(0, POOL_SIZE - 1)),
                        MASK_W'($urandom));
            else if (roll < 85)
                send_op(MODE_DELETE, pool_key($urandom_range(0, POOL_SIZE - 1)),
                        MASK_W'($urandom));
            else if (roll < 95)
                send_op(MODE_W'($urandom_range(MODE_ADD, MODE_QUERY)),
                        KEY_W'($urandom), MASK_W'($urandom));
            else
                send_op(MODE_UNUSED, pool_key($urandom_range(0, POOL_SIZE - 1)),
                        MASK_W'($urandom));
        end

        shuffle_pool();
        foreach (order[i])
            send_op(MODE_DELETE, pool_key(order[i]), MASK_W'($urandom));

        wait_drained();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_idle_pct  = 0;
        m_stall_pct = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, key extremes, update, absent keys, unused code
        send_op(MODE_QUERY,  16'sd0,      16'hFFFF);
        send_op(MODE_DELETE, 16'sd5,      16'h0000);
        send_op(MODE_ADD,    16'sh8000,   16'hFFFF);
        send_op(MODE_ADD,    16'sh7FFF,   16'h0000);
        send_op(MODE_ADD,    16'sd0,      16'h1234);
        send_op(MODE_ADD,    -16'sd1,     16'h8000);
        send_op(MODE_ADD,    16'sd1,      16'h0001);
        send_op(MODE_QUERY,  16'sh8000,   16'h0000);
        send_op(MODE_QUERY,  16'sh7FFF,   16'h0000);
        send_op(MODE_QUERY,  -16'sd1,     16'h0000);
        send_op(MODE_ADD,    16'sd0,      16'hABCD);
        send_op(MODE_QUERY,  16'sd0,      16'h0000);
        send_op(MODE_QUERY,  16'sd2,      16'h0000);
        send_op(MODE_UNUSED, 16'sh7FFF,   16'hFFFF);
        send_op(MODE_DELETE, 16'sh8000,   16'h0000);
        send_op(MODE_DELETE, 16'sh7FFF,   16'h0000);
        send_op(MODE_DELETE, 16'sd100,    16'h0000);
        send_op(MODE_QUERY,  16'sh8000,   16'h0000);
        send_op(MODE_DELETE, 16'sd0,      16'h0000);
        send_op(MODE_DELETE, -16'sd1,     16'h0000);
        send_op(MODE_DELETE, 16'sd1,      16'h0000);
        send_op(MODE_DELETE, 16'sd1,      16'h0000);
        send_op(MODE_ADD,    16'sh5555,   16'hAAAA);
        send_op(MODE_QUERY,  16'sh5555,   16'h0000);
        send_op(MODE_UNUSED, 16'sd0,      16'h0000);
        wait_drained();

        // random rounds: free flow, slow sender, slow receiver, both
        run_round(0, 0);
        run_round(61, 0);
        run_round(0, 61);
        run_round(12, 12);

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("tb_sorted_key_table_top: clean");
        else
            $display("tb_sorted_key_table_top: errors");
        $finish;
    end

endmodule
